@@ src/ffr_pkg.sv @@
package ffr_pkg;

   // Frame layout and marker bytes.
   localparam int unsigned FRAME_LENGTH = 9;
   localparam int unsigned STORE_DEPTH = 8;
   localparam int unsigned BCC_SPAN = 7;
   localparam int unsigned POS_WIDTH = 4;
   localparam int unsigned IDX_WIDTH = $clog2(STORE_DEPTH);

   localparam logic [7:0] HDR_BYTE = 8'h7A;
   localparam logic [7:0] TAIL_BYTE = 8'h7B;

   localparam logic [POS_WIDTH-1:0] POS_IDLE = '0;
   localparam logic [POS_WIDTH-1:0] POS_FIRST = POS_WIDTH'(1);
   localparam logic [POS_WIDTH-1:0] POS_LAST = POS_WIDTH'(FRAME_LENGTH - 1);

   // Frame byte positions.
   localparam int unsigned ADDR_POS = 1;
   localparam int unsigned KIND_POS = 2;
   localparam int unsigned VALUE_POS = 3;
   localparam int unsigned BCC_POS = 7;

   // Control register map.
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_VALID_ADDRESS = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_FEEDBACK_KIND = CSR_INDEX_WIDTH'(1);

   localparam logic [7:0] MIN_VALID_ADDRESS_RESET = 8'd1;
   localparam logic [7:0] MAX_FEEDBACK_KIND_RESET = 8'd7;

   typedef logic [STORE_DEPTH-1:0][7:0] frame_type;

   typedef struct packed {
      logic [7:0] min_valid_address;
      logic [7:0] max_feedback_kind;
   } cfg_type;

endpackage

@@ src/ffr_frame_check.sv @@
module ffr_frame_check
   import ffr_pkg::*;
(
   input  frame_type  frame,
   input  logic [7:0] last_byte,
   input  cfg_type    cfg,
   output logic       frame_ok
);

   logic [7:0] bcc;

   always_comb begin
      bcc = '0;
      for (int i = 0; i < BCC_SPAN; i++) begin
         bcc = bcc ^ frame[i];
      end
   end

   // All five frame checks must pass for the frame to be reported.
   assign frame_ok = (frame[0] == HDR_BYTE)
                  && (last_byte == TAIL_BYTE)
                  && (frame[ADDR_POS] >= cfg.min_valid_address)
                  && (frame[KIND_POS] <= cfg.max_feedback_kind)
                  && (bcc == frame[BCC_POS]);

endmodule

@@ src/feedback_frame_receiver_unit.sv @@
// The tail byte passes the input register, then its result the result register.
// Throughput: one received byte per cycle while results are taken; the input and
// result registers let a new byte enter while a finished result still waits.
// Reset (synchronous, active high) returns the deframer to header search, empties
// both registers and restores min_valid_address to 1 and max_feedback_kind to 7.
module feedback_frame_receiver_unit
   import ffr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_rx_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_source_address,
   output logic [7:0]                 rsp_feedback_kind,
   output logic signed [31:0]         rsp_raw_value,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   // Control registers.
   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Input register: one received byte waiting to be processed.
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;

   // Deframer state: bytes collected so far and the stored frame bytes.
   logic [POS_WIDTH-1:0] pos_ff;
   logic [POS_WIDTH-1:0] pos_in;
   frame_type            frame_ff;

   // Result register.
   logic              out_valid_ff;
   logic              out_valid_in;
   logic [7:0]        out_addr_ff;
   logic [7:0]        out_kind_ff;
   logic signed [31:0] out_value_ff;

   logic                 out_free;
   logic                 advance;
   logic                 is_last;
   logic                 frame_ok;
   logic                 emit;
   logic                 store_en;
   logic [IDX_WIDTH-1:0] store_idx;

   // The result register is free when empty or being taken this cycle. The
   // input register moves on whenever the result register is free, so a byte
   // can enter every cycle as long as results are taken.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   assign is_last = (pos_ff == POS_LAST);

   ffr_frame_check u_check (
      .frame     (frame_ff),
      .last_byte (in_byte_ff),
      .cfg       (cfg_ff),
      .frame_ok  (frame_ok)
   );

   assign emit = advance && is_last && frame_ok;

   // Next position and frame store write. While searching, only a header
   // starts a frame. Inside a frame every byte is stored as data. After the
   // last byte the deframer goes idle, except that a rejected frame whose last
   // byte is a header restarts with that byte as the new frame's first byte.
   always_comb begin
      pos_in    = pos_ff;
      store_en  = 1'b0;
      store_idx = pos_ff[IDX_WIDTH-1:0];
      if (advance) begin
         priority if (pos_ff == POS_IDLE) begin
            if (in_byte_ff == HDR_BYTE) begin
               store_en  = 1'b1;
               store_idx = '0;
               pos_in    = POS_FIRST;
            end
         end else if (!is_last) begin
            store_en = 1'b1;
            pos_in   = pos_ff + POS_FIRST;
         end else begin
            pos_in = POS_IDLE;
            if (!frame_ok && (in_byte_ff == HDR_BYTE)) begin
               store_en  = 1'b1;
               store_idx = '0;
               pos_in    = POS_FIRST;
            end
         end
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MIN_VALID_ADDRESS: cfg_in.min_valid_address = csr_write_data;
            CSR_MAX_FEEDBACK_KIND: cfg_in.max_feedback_kind = csr_write_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_valid_address <= MIN_VALID_ADDRESS_RESET;
         cfg_ff.max_feedback_kind <= MAX_FEEDBACK_KIND_RESET;
         in_valid_ff              <= 1'b0;
         pos_ff                   <= POS_IDLE;
         out_valid_ff             <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (store_en) begin
         frame_ff[store_idx] <= in_byte_ff;
      end
      if (emit) begin
         out_addr_ff  <= frame_ff[ADDR_POS];
         out_kind_ff  <= frame_ff[KIND_POS];
         out_value_ff <= {frame_ff[VALUE_POS], frame_ff[VALUE_POS+1],
                          frame_ff[VALUE_POS+2], frame_ff[VALUE_POS+3]};
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_source_address = out_addr_ff;
   assign rsp_feedback_kind  = out_kind_ff;
   assign rsp_raw_value      = out_value_ff;

endmodule

@@ src/ffr_checker.sv @@
module ffr_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [7:0]         rsp_source_address,
   input logic [7:0]         rsp_feedback_kind,
   input logic signed [31:0] rsp_raw_value
);

   // A result beat that is not taken stays, unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_source_address)
         && $stable(rsp_feedback_kind) && $stable(rsp_raw_value))
      else $error("result beat changed before it was taken");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending right after reset");

   // With no result waiting, the input side never stalls.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with an empty result register");

   // A new result must follow a byte beat that was taken earlier.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result appeared without a matching byte beat");

endmodule

bind feedback_frame_receiver_unit ffr_checker u_ffr_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_source_address (rsp_source_address),
   .rsp_feedback_kind  (rsp_feedback_kind),
   .rsp_raw_value      (rsp_raw_value)
);

@@ tb/tb_feedback_frame_receiver_unit.sv @@
`timescale 1ns / 100ps

module tb_feedback_frame_receiver_unit;
   import ffr_pkg::*;

   // One decoded feedback report as it leaves the result channel.
   typedef struct packed {
      logic [7:0]         source_address;
      logic [7:0]         feedback_kind;
      logic signed [31:0] raw_value;
   } feedback_report_type;

   localparam int unsigned RESET_CYCLES = 7;
   localparam int unsigned PHASE_COUNT = 6;
   localparam int unsigned PHASE_BYTES = 275;
   // A result passes the input and result registers after the tail beat; rejected frames
   // leave no trace, so every quiet point waits a little longer before touching registers.
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT = 200000;

   // Register indexes that the block does not map. Writes there must be ignored.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED_LOW = CSR_INDEX_WIDTH'(2);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED_HIGH = CSR_INDEX_WIDTH'(3);

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [7:0]                 req_rx_byte = 8'h00;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [7:0]                 rsp_source_address;
   logic [7:0]                 rsp_feedback_kind;
   logic signed [31:0]         rsp_raw_value;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data = '0;

   // Bytes waiting to be offered on the input channel, and the reports that the
   // deframer model says must come out, oldest first.
   logic [7:0]          pending_rx_bytes[$];
   feedback_report_type expected_reports[$];

   // Shadow copy of the deframer: register values, byte position and frame store.
   cfg_type          cfg_shadow = '{min_valid_address: MIN_VALID_ADDRESS_RESET,
                                    max_feedback_kind: MAX_FEEDBACK_KIND_RESET};
   logic [POS_WIDTH-1:0] frame_pos = POS_IDLE;
   frame_type        frame_store = '0;

   int unsigned      sender_idle_pct = 0;
   int unsigned      receiver_stall_pct = 0;
   int unsigned      queued_count = 0;
   int unsigned      cycle_count = 0;
   int unsigned      mismatch_count = 0;

   feedback_frame_receiver_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_source_address (rsp_source_address),
      .rsp_feedback_kind  (rsp_feedback_kind),
      .rsp_raw_value      (rsp_raw_value),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Deframer model. It takes one accepted byte and, when that byte closes a frame
   // that passes every check, queues the report the block has to produce.
   task automatic deframe_byte(input logic [7:0] rx);
      logic [7:0]          check;
      feedback_report_type report;
      if (frame_pos == POS_IDLE) begin
         // Anything but a header is thrown away while hunting for a frame.
         if (rx == HDR_BYTE) begin
            frame_store[0] = rx;
            frame_pos = POS_FIRST;
         end
      end else if (frame_pos < POS_LAST) begin
         // Header bytes inside a frame are plain data; there is no early resync.
         frame_store[frame_pos[IDX_WIDTH-1:0]] = rx;
         frame_pos = frame_pos + POS_FIRST;
      end else begin
         frame_pos = POS_IDLE;
         check = '0;
         for (int i = 0; i < BCC_SPAN; i++) begin
            check = check ^ frame_store[i];
         end
         if (frame_store[0] == HDR_BYTE && rx == TAIL_BYTE &&
             frame_store[ADDR_POS] >= cfg_shadow.min_valid_address &&
             frame_store[KIND_POS] <= cfg_shadow.max_feedback_kind &&
             check == frame_store[BCC_POS]) begin
            report.source_address = frame_store[ADDR_POS];
            report.feedback_kind = frame_store[KIND_POS];
            report.raw_value = {frame_store[VALUE_POS], frame_store[VALUE_POS + 1],
                                frame_store[VALUE_POS + 2], frame_store[VALUE_POS + 3]};
            expected_reports.push_back(report);
         end else if (rx == HDR_BYTE) begin
            // A rejected frame whose last byte is a header opens the next frame.
            frame_store[0] = rx;
            frame_pos = POS_FIRST;
         end
      end
   endtask

   // Input driver. A new beat is only loaded once the current one has been taken,
   // so valid and the payload hold steady while the block is not ready.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_rx_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_valid <= 1'b1;
            req_rx_byte <= pending_rx_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result channel back-pressure.
   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= receiver_stall_pct);
   end

   // Every byte the block takes is run through the model at the same edge.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         deframe_byte(req_rx_byte);
      end
   end

   // Result monitor. Each accepted report is held against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         feedback_report_type want;
         if (expected_reports.size() == 0) begin
            $error("unexpected report: source_address %h, feedback_kind %h, raw_value %0d",
                   rsp_source_address, rsp_feedback_kind, rsp_raw_value);
            mismatch_count++;
         end else begin
            want = expected_reports.pop_front();
            if (rsp_source_address !== want.source_address) begin
               $error("source_address mismatch: expected %h, actual %h",
                      want.source_address, rsp_source_address);
               mismatch_count++;
            end
            if (rsp_feedback_kind !== want.feedback_kind) begin
               $error("feedback_kind mismatch: expected %h, actual %h",
                      want.feedback_kind, rsp_feedback_kind);
               mismatch_count++;
            end
            if (rsp_raw_value !== want.raw_value) begin
               $error("raw_value mismatch: expected %0d, actual %0d",
                      $signed(want.raw_value), rsp_raw_value);
               mismatch_count++;
            end
         end
      end
   end

   task automatic queue_byte(input logic [7:0] value);
      pending_rx_bytes.push_back(value);
      queued_count++;
   endtask

   // Builds one frame. The check byte can be spoiled by a nonzero flip mask, the
   // tail can be replaced, and the header can be left off when an earlier rejected
   // frame already supplied it.
   task automatic queue_frame(input logic [7:0] addr, input logic [7:0] kind,
                              input logic [31:0] value, input logic [7:0] bcc_flip,
                              input logic [7:0] tail, input bit with_header);
      logic [7:0] bcc;
      bcc = HDR_BYTE ^ addr ^ kind ^ value[31:24] ^ value[23:16] ^ value[15:8] ^
            value[7:0] ^ bcc_flip;
      if (with_header) begin
         queue_byte(HDR_BYTE);
      end
      queue_byte(addr);
      queue_byte(kind);
      queue_byte(value[31:24]);
      queue_byte(value[23:16]);
      queue_byte(value[15:8]);
      queue_byte(value[7:0]);
      queue_byte(bcc);
      queue_byte(tail);
   endtask

   // One random piece of traffic. Most pieces are well-formed frames whose fields
   // mostly sit inside the programmed limits; the rest are broken frames and noise.
   task automatic queue_random_piece();
      int unsigned roll;
      int unsigned pick;
      logic [7:0]  addr;
      logic [7:0]  kind;
      logic [31:0] value;
      pick = $urandom_range(99);
      if (pick < 10) begin
         addr = cfg_shadow.min_valid_address;
      end else if (pick < 75) begin
         addr = 8'($urandom_range(255, cfg_shadow.min_valid_address));
      end else begin
         addr = 8'($urandom_range(255));
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
         kind = cfg_shadow.max_feedback_kind;
      end else if (pick < 75) begin
         kind = 8'($urandom_range(cfg_shadow.max_feedback_kind, 0));
      end else begin
         kind = 8'($urandom_range(255));
      end
      case ($urandom_range(19))
         0: value = 32'h8000_0000;
         1: value = 32'h7FFF_FFFF;
         2: value = 32'hFFFF_FFFF;
         3: value = 32'h0000_0000;
         4: value = {4{HDR_BYTE}};
         default: value = $urandom;
      endcase

      roll = $urandom_range(99);
      if (roll < 60) begin
         queue_frame(addr, kind, value, 8'h00, TAIL_BYTE, 1'b1);
      end else if (roll < 70) begin
         queue_frame(addr, kind, value, 8'($urandom_range(255, 1)), TAIL_BYTE, 1'b1);
      end else if (roll < 77) begin
         queue_frame(addr, kind, value, 8'h00, 8'($urandom_range(255)), 1'b1);
      end else if (roll < 85) begin
         // The rejected frame ends in a header, so the follow-up frame comes without one.
         queue_frame(addr, kind, value, 8'h00, HDR_BYTE, 1'b1);
         queue_frame(addr, kind, value, 8'h00, TAIL_BYTE, 1'b0);
      end else if (roll < 93) begin
         repeat ($urandom_range(6, 1)) queue_byte(8'($urandom_range(255)));
      end else begin
         // A cut-off frame; whatever follows is swallowed as its remaining bytes.
         queue_byte(HDR_BYTE);
         repeat ($urandom_range(7, 1)) queue_byte(8'($urandom_range(255)));
      end
   endtask

   // Registers are written with the block idle, and the shadow copy follows the edge
   // at which the write lands.
   task automatic program_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                   input logic [7:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         CSR_MIN_VALID_ADDRESS: cfg_shadow.min_valid_address = data;
         CSR_MAX_FEEDBACK_KIND: cfg_shadow.max_feedback_kind = data;
         default: ;
      endcase
   endtask

   // Waits until every queued byte has gone in and every expected report has come
   // out, then lets the pipeline empty of any frame that was rejected on the way.
   task automatic wait_for_drain();
      do @(posedge clock);
      while (pending_rx_bytes.size() != 0 || req_valid || expected_reports.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Watchdog. A hung handshake or a report that never arrives ends up here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed traffic under the reset limits. Idle noise comes first, including a
      // stray tail. Then a frame on the address and type limits whose last byte is a
      // header, so it is rejected and reopens the next frame; that next frame carries
      // header bytes as data and must be accepted.
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_byte(TAIL_BYTE);
      queue_frame(MIN_VALID_ADDRESS_RESET, MAX_FEEDBACK_KIND_RESET, 32'h8000_0000,
                  8'h00, HDR_BYTE, 1'b1);
      queue_frame(8'hFF, 8'h00, {4{HDR_BYTE}}, 8'h00, TAIL_BYTE, 1'b0);
      wait_for_drain();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               program_register(CSR_MIN_VALID_ADDRESS, 8'h00);
               program_register(CSR_MAX_FEEDBACK_KIND, 8'hFF);
            end
            1: begin
               program_register(CSR_MIN_VALID_ADDRESS, 8'hFF);
               program_register(CSR_MAX_FEEDBACK_KIND, 8'h00);
            end
            2: begin
               program_register(CSR_MIN_VALID_ADDRESS, 8'($urandom_range(255)));
               program_register(CSR_MAX_FEEDBACK_KIND, 8'($urandom_range(255)));
               // Unmapped indexes must leave both limits alone.
               program_register(CSR_UNMAPPED_LOW, 8'($urandom_range(255)));
               program_register(CSR_UNMAPPED_HIGH, 8'($urandom_range(255)));
            end
            3: begin
               program_register(CSR_MIN_VALID_ADDRESS, 8'hFF);
               program_register(CSR_MAX_FEEDBACK_KIND, 8'hFF);
            end
            4: begin
               program_register(CSR_MIN_VALID_ADDRESS, 8'h00);
               program_register(CSR_MAX_FEEDBACK_KIND, 8'h00);
            end
            default: begin
               program_register(CSR_MIN_VALID_ADDRESS, MIN_VALID_ADDRESS_RESET);
               program_register(CSR_MAX_FEEDBACK_KIND, MAX_FEEDBACK_KIND_RESET);
            end
         endcase

         // Flow-control pattern rotates: none, idle sender, stalling receiver, both light.
         case (phase % 4)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 85;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 85;
            end
            default: begin
               sender_idle_pct = 6;
               receiver_stall_pct = 6;
            end
         endcase

         // Halfway through, the sender holds off until every report has been seen,
         // which also leaves the deframer parked in the middle of a frame at times.
         queued_count = 0;
         while (queued_count < PHASE_BYTES / 2) queue_random_piece();
         wait_for_drain();
         while (queued_count < PHASE_BYTES) queue_random_piece();
         wait_for_drain();
      end

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
